// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// Depends on nothing; the interfaces, the allocator and the testbench import it.
package ffba_pkg;

   localparam int DefaultMaxEntries = 16;
   localparam int DefaultMaxUnits   = 1024;

   localparam int ReqBytesW  = 15;
   localparam int AddrW      = 32;
   localparam int UsedW      = 15;
   localparam int CapW       = 11;
   localparam int UnitsW     = 12;   // request_bytes rounded up to granules
   localparam int GranShift  = 4;    // 16-byte granules
   localparam int CsrIndexW  = 1;
   localparam int CsrDataW   = 32;

   typedef enum logic [0:0] {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_CAPACITY = 1'b0,
      CSR_BASE     = 1'b1
   } csr_index_type;

   localparam logic [CapW-1:0]  CapacityReset = 11'd1024;
   localparam logic [AddrW-1:0] BaseReset     = 32'd0;

endpackage

// ===== src/ffba_req_if.sv =====
// Request channel of the allocator: valid/ready handshake and payload.
// Depends on ffba_pkg for the field widths.
interface ffba_req_if;
   import ffba_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [0:0]           action;
   logic [ReqBytesW-1:0] request_bytes;
   logic [AddrW-1:0]     release_address;

   modport source (output valid, action, request_bytes, release_address, input ready);
   modport sink   (input valid, action, request_bytes, release_address, output ready);
endinterface

// ===== src/ffba_rsp_if.sv =====
// Response channel of the allocator: valid/ready handshake and payload.
// Depends on ffba_pkg for the field widths.
interface ffba_rsp_if;
   import ffba_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [AddrW-1:0] address;
   logic [UsedW-1:0] used_bytes;

   modport source (output valid, status, address, used_bytes, input ready);
   modport sink   (input valid, status, address, used_bytes, output ready);
endinterface

// ===== src/ffba_table.sv =====
// Allocation table storage: one write port, one read port, registered read.
// Depends on nothing beyond its parameters.
module ffba_table #(
   parameter int Depth = 16,
   parameter int DataW = 21
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [DataW-1:0]                       wr_data,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [DataW-1:0]                       rd_data
);
   logic [DataW-1:0] mem [Depth];
   logic [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit allocator over a region of 16-byte granules.
// Requests arrive on req (valid/ready), results leave on rsp (valid/ready).
// A request transaction is taken only while the sequencer is idle; one
// response transaction follows for every request, in order.
// An allocate walks the table entry by entry through the single read port
// of the table memory. When an entry overlaps the candidate span, the
// candidate jumps to that entry's end and the walk restarts. With n entries
// an allocate makes at most n such jumps. A release walks the table for the
// address and then moves every later entry down by one place, one entry per
// cycle. Zero-size and full-table requests go from idle straight to the
// finish state, with no table walk. The response is held in an output
// register; a stalled receiver holds the block only after it has finished
// the next request as well. Reset (synchronous, active high) empties the
// table, clears the used total and restores capacity 1024 granules and base
// address 0. The table memory needs no clearing pass: only entries below
// the count are ever read. Configuration registers are to be written through
// csr_* only while the block is idle; the user must keep to this, as the
// block itself does not enforce it.
module first_fit_block_allocator #(
   parameter int MAX_ENTRIES = ffba_pkg::DefaultMaxEntries,
   parameter int MAX_UNITS   = ffba_pkg::DefaultMaxUnits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ffba_pkg::CsrIndexW-1:0] csr_index,
   input  logic [ffba_pkg::CsrDataW-1:0] csr_wdata,
   ffba_req_if.sink                      req,
   ffba_rsp_if.source                    rsp
);
   import ffba_pkg::*;

   localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int OW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int SW  = $clog2(MAX_UNITS + 1);
   localparam int XW  = ((SW > UnitsW) ? SW : UnitsW) + 2;
   localparam int EW  = OW + SW;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);
   localparam logic [XW-1:0] MaxUnitsX = XW'(MAX_UNITS);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_SEARCH = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CapW-1:0]  cap_ff;
   logic [AddrW-1:0] base_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [UsedW-1:0] used_ff, used_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [CW-1:0]    wj_ff, wj_in;
   logic [XW-1:0]    off_ff, off_in;
   logic [XW-1:0]    units_ff, units_in;
   logic [AddrW-1:0] rel_ff, rel_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [AddrW-1:0] res_addr_ff, res_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic [AddrW-1:0] rsp_addr_ff;
   logic [UsedW-1:0] rsp_used_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [XW-1:0] ent_start, ent_size, cap_eff, req_units;
   logic [AddrW-1:0] ent_addr;
   logic          overlap;
   logic          req_fire, rsp_load;

   ffba_table #(.Depth(MAX_ENTRIES), .DataW(EW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_start = XW'(rd_data[EW-1:SW]);
   assign ent_size  = XW'(rd_data[SW-1:0]);
   assign ent_addr  = base_ff + (AddrW'(rd_data[EW-1:SW]) << GranShift);
   assign overlap   = (ent_start < off_ff + units_ff) && (off_ff < ent_start + ent_size);
   assign cap_eff   = (XW'(cap_ff) > MaxUnitsX) ? MaxUnitsX : XW'(cap_ff);
   assign req_units = XW'(({1'b0, req.request_bytes} + (ReqBytesW + 1)'(15)) >> GranShift);

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      wj_in         = wj_ff;
      off_in        = off_ff;
      units_in      = units_ff;
      rel_in        = rel_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {off_ff[OW-1:0], units_ff[SW-1:0]};
      rd_addr       = idx_ff[AW-1:0];

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               units_in    = req_units;
               rel_in      = req.release_address;
               off_in      = '0;
               idx_in      = '0;
               res_addr_in = '0;
               if (req.action == ACT_RELEASE) begin
                  state_in = S_SEARCH;
               end else if (req_units == '0) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_FINISH;
               end else if (count_ff >= MaxCount) begin
                  res_status_in = ST_FULL;
                  state_in      = S_FINISH;
               end else if (req_units > cap_eff) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && overlap) begin
               // Every offset from here up to this entry's end collides too.
               off_in = ent_start + ent_size;
               idx_in = '0;
               if (ent_start + ent_size + units_ff > cap_eff) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_FINISH;
               end
            end else if (idx_ff < count_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               wr_en         = 1'b1;
               count_in      = count_ff + 1'b1;
               used_in       = used_ff + (UsedW'(units_ff) << GranShift);
               res_status_in = ST_OK;
               res_addr_in   = base_ff + (AddrW'(off_ff) << GranShift);
               state_in      = S_FINISH;
            end
         end
         S_SEARCH: begin
            if (pend_ff && ent_addr == rel_ff) begin
               used_in       = used_ff - (UsedW'(ent_size) << GranShift);
               res_status_in = ST_OK;
               idx_in        = idx_ff;
               wj_in         = idx_ff - 1'b1;
               state_in      = S_SHIFT;
            end else if (idx_ff < count_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT: begin
            // Read entry idx, write it one place lower in the next cycle.
            wr_addr = wj_ff[AW-1:0];
            wr_data = rd_data;
            if (pend_ff) begin
               wr_en = 1'b1;
               wj_in = wj_ff + 1'b1;
            end
            if (idx_ff < count_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CapacityReset;
         base_ff      <= BaseReset;
         count_ff     <= '0;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff  <= csr_wdata[CapW-1:0];
               CSR_BASE:     base_ff <= csr_wdata[AddrW-1:0];
               default:      ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      wj_ff         <= wj_in;
      off_ff        <= off_in;
      units_ff      <= units_in;
      rel_ff        <= rel_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_used_ff   <= used_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.address    = rsp_addr_ff;
   assign rsp.used_bytes = rsp_used_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("entry count beyond table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a request transaction");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && pend_ff) |-> wj_ff < count_ff)
      else $error("compaction write beyond live entries");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for first_fit_block_allocator: directed, register-extreme,
// random, back-pressure and no-idle tests, each result checked against an in-bench allocator model.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and the allocator RTL.
module tb;
   import ffba_pkg::*;

   localparam int TableDepth = 16;
   localparam int RegionUnits = 1024;

   typedef struct {
      status_type       status;
      logic [AddrW-1:0] address;
      logic [UsedW-1:0] used_bytes;
   } alloc_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   ffba_req_if req_if ();
   ffba_rsp_if rsp_if ();

   first_fit_block_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_if.sink),
      .rsp       (rsp_if.source)
   );

   always #10 clock = ~clock;

   // Model of the allocation table and registers.
   logic [9:0]       model_start [TableDepth];
   logic [10:0]      model_size [TableDepth];
   int               model_count;
   logic [UsedW-1:0] model_used;
   logic [CapW-1:0]  model_capacity;
   logic [AddrW-1:0] model_base;

   alloc_result_type expected_results[$];
   int  error_count = 0;
   bit  idle_enable = 1'b1;
   int  receiver_hold = 0;

   function automatic bit span_is_free(int off, int units);
      for (int i = 0; i < model_count; i++) begin
         if (model_start[i] < off + units && off < model_start[i] + model_size[i])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic alloc_result_type predict_allocation(action_type act,
         logic [ReqBytesW-1:0] bytes, logic [AddrW-1:0] rel_addr);
      alloc_result_type r;
      int units;
      int cap;
      r.status = ST_NO_SPACE;
      r.address = '0;
      if (act == ACT_ALLOC) begin
         units = (int'(bytes) + 15) >> GranShift;
         cap = (model_capacity > RegionUnits) ? RegionUnits : int'(model_capacity);
         if (units == 0) begin
            r.status = ST_NO_SPACE;
         end else if (model_count >= TableDepth) begin
            r.status = ST_FULL;
         end else begin
            for (int off = 0; off + units <= cap; off++) begin
               if (span_is_free(off, units)) begin
                  model_start[model_count] = off[9:0];
                  model_size[model_count] = units[10:0];
                  model_count++;
                  model_used = model_used + UsedW'(units * 16);
                  r.status = ST_OK;
                  r.address = model_base + AddrW'(off * 16);
                  break;
               end
            end
         end
      end else begin
         r.status = ST_NOT_FOUND;
         for (int i = 0; i < model_count; i++) begin
            if (model_base + AddrW'(int'(model_start[i]) * 16) == rel_addr) begin
               model_used = model_used - UsedW'(int'(model_size[i]) * 16);
               for (int j = i; j + 1 < model_count; j++) begin
                  model_start[j] = model_start[j + 1];
                  model_size[j] = model_size[j + 1];
               end
               model_count--;
               r.status = ST_OK;
               break;
            end
         end
      end
      r.used_bytes = model_used;
      return r;
   endfunction

   // Sends one request; valid stays high afterwards unless the next call idles or wait_drained drops it.
   task automatic send_request(action_type act, logic [ReqBytesW-1:0] bytes,
         logic [AddrW-1:0] rel_addr);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.action          <= act;
      req_if.request_bytes   <= bytes;
      req_if.release_address <= rel_addr;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_allocation(act, bytes, rel_addr));
   endtask

   task automatic alloc(int bytes);
      send_request(ACT_ALLOC, ReqBytesW'(bytes), $urandom);
   endtask

   task automatic release_addr(logic [AddrW-1:0] a);
      send_request(ACT_RELEASE, ReqBytesW'($urandom), a);
   endtask

   function automatic logic [AddrW-1:0] live_address();
      int i;
      if (model_count == 0)
         return $urandom;
      i = $urandom_range(0, model_count - 1);
      return model_base + AddrW'(int'(model_start[i]) * 16);
   endfunction

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CsrDataW-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CAPACITY)
         model_capacity = value[CapW-1:0];
      else
         model_base = value;
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         alloc($urandom_range(1, 512));
      else if (pick < 56)
         alloc($urandom_range(0, 32767));
      else if (pick < 60)
         alloc($urandom_range(0, 16));
      else if (pick < 92)
         release_addr(live_address());
      else
         release_addr($urandom);
   endtask

   task automatic test_directed();
      alloc(0);
      alloc(1);
      alloc(16);
      alloc(17);
      alloc(32767);
      release_addr(32'd0);
      release_addr(32'd0);
      release_addr(32'hFFFF_FFFF);
      release_addr(live_address());
      release_addr(live_address());
      alloc(16384);
      alloc(16);
      release_addr(32'd0);
      for (int i = 0; i < 17; i++) alloc(16);
      alloc(0);
      release_addr(32'd80);
      release_addr(32'd16);
      alloc(32);
      alloc(16);
      while (model_count > 0) release_addr(live_address());
   endtask

   task automatic test_register_extremes();
      write_register(CSR_CAPACITY, 32'd0);
      alloc(16);
      alloc(0);
      write_register(CSR_CAPACITY, 32'h7FF);
      alloc(16384);
      alloc(16);
      release_addr(32'd0);
      write_register(CSR_CAPACITY, 32'd1);
      alloc(16);
      alloc(16);
      alloc(17);
      write_register(CSR_BASE, 32'hFFFF_FFF0);
      release_addr(32'hFFFF_FFF0);
      write_register(CSR_CAPACITY, 32'd4);
      alloc(48);
      alloc(16);
      alloc(16);
      release_addr(32'd0);
      release_addr(32'hFFFF_FFF0);
      while (model_count > 0) release_addr(live_address());
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_CAPACITY, 32'd1024);
               write_register(CSR_BASE, $urandom);
            end
            1: begin
               write_register(CSR_CAPACITY, $urandom_range(16, 200));
            end
            2: begin
               write_register(CSR_CAPACITY, $urandom_range(1025, 2047));
               write_register(CSR_BASE, 32'hFFFF_FF00);
            end
            default: begin
               write_register(CSR_CAPACITY, $urandom_range(1, 64));
               write_register(CSR_BASE, 32'd0);
            end
         endcase
         repeat (115) random_request();
      end
   endtask

   task automatic test_backpressure();
      write_register(CSR_CAPACITY, 32'd1024);
      receiver_hold = 400;
      repeat (30) random_request();
   endtask

   task automatic test_no_idle();
      wait_drained();
      idle_enable = 1'b0;
      repeat (60) random_request();
   endtask

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      static int stall_left = 0;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (receiver_hold > 0) begin
         receiver_hold = receiver_hold - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("response transaction with no request outstanding");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.address !== want.address) begin
               $error("address: expected %h, actual %h", want.address, rsp_if.address);
               error_count++;
            end
            if (rsp_if.used_bytes !== want.used_bytes) begin
               $error("used_bytes: expected %0d, actual %0d", want.used_bytes,
                      rsp_if.used_bytes);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_CAPACITY;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.action = ACT_ALLOC;
      req_if.request_bytes = '0;
      req_if.release_address = '0;
      rsp_if.ready = 1'b0;
      model_count = 0;
      model_used = '0;
      model_capacity = CapacityReset;
      model_base = BaseReset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_phases();
      test_backpressure();
      test_no_idle();

      wait_drained();
      repeat (400) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("** first_fit_block_allocator: PASSED **");
      else
         $display("** first_fit_block_allocator: FAILED **");
      $finish;
   end

   initial begin
      #60000000;
      $display("** first_fit_block_allocator: FAILED **");
      $finish;
   end

endmodule
